@@ hw/rtl/rpn_pkg.sv @@
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants for the RPN expression evaluator
// Character codes, command classes and the queue entry format.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_PUSH,
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV,
    CMD_BAD
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] digit;
    logic       last;
  } qent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_EXEC,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

@@ hw/rtl/rpn_ram.sv @@
// ----------------------------------------------------------------------------
// rpn_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/rpn_front.sv @@
// ----------------------------------------------------------------------------
// rpn_front: character classifier and command queue
// Turns each character into a command and buffers up to four for the back end.
// ----------------------------------------------------------------------------
module rpn_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         symbol,
  input  logic               end_of_expr,
  output logic               q_valid,
  input  logic               q_pop,
  output rpn_pkg::qent_t     q_data
);
  import rpn_pkg::*;

  localparam int QD = 4;

  qent_t      buf_q [QD];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  qent_t      ent;
  logic       push;

  always_comb begin
    ent.digit = symbol[3:0] - CH_ZERO[3:0];
    ent.last  = end_of_expr;
    unique case (symbol)
      CH_SPACE: ent.cmd = CMD_NONE;
      CH_PLUS:  ent.cmd = CMD_ADD;
      CH_MINUS: ent.cmd = CMD_SUB;
      CH_MUL:   ent.cmd = CMD_MUL;
      CH_DIV:   ent.cmd = CMD_DIV;
      default:  ent.cmd = (symbol >= CH_ZERO && symbol <= CH_ZERO + 8'd9) ? CMD_PUSH
                                                                          : CMD_BAD;
    endcase
  end

  assign in_stall = (cnt == 3'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != 3'd0);
  assign q_data   = buf_q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wp] <= ent;
    end
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (q_pop) rp <= rp + 2'd1;
      cnt <= cnt + 3'(push) - 3'(q_pop);
    end
  end
endmodule

@@ hw/rtl/rpn_back.sv @@
// ----------------------------------------------------------------------------
// rpn_back: stack execution unit
// Pops commands, runs them on the operand stack, and emits the result.
// ----------------------------------------------------------------------------
module rpn_back #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  rpn_pkg::qent_t     q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic               error
);
  import rpn_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  state_t        state, state_next;
  qent_t         cur;
  logic [DW-1:0] depth;
  logic          err_seen;
  logic          last_op;
  logic [31:0]   top;     // cached top of stack
  logic [31:0]   bot0;    // cached entry 0 for the result

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  // divider
  logic [5:0]    dcnt;
  logic [31:0]   dq, dr, dd;
  logic          dneg;
  logic [32:0]   dtrial;

  logic          op_cmd;
  logic          fin_err;

  rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign op_cmd = (cur.cmd == CMD_ADD) || (cur.cmd == CMD_SUB) ||
                  (cur.cmd == CMD_MUL) || (cur.cmd == CMD_DIV);
  assign dtrial = {dr, dq[31]} - {1'b0, dd};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (q_valid) state_next = ST_RD;
      ST_RD:   state_next = ST_EXEC;
      ST_EXEC: begin
        if (!err_seen && cur.cmd == CMD_DIV && depth >= DW'(2) && top != 32'd0)
          state_next = ST_DIV;
        else if (cur.last) state_next = ST_OUT;
        else state_next = ST_IDLE;
      end
      ST_DIV: if (dcnt == 6'd0) state_next = cur.last ? ST_OUT : ST_IDLE;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == ST_IDLE) && q_valid;
    out_valid = (state == ST_OUT);
    raddr     = AW'(depth - DW'(2));
  end

  assign fin_err = err_seen || depth != DW'(1) || !last_op;
  assign value   = fin_err ? 32'sd0 : $signed(bot0);
  assign error   = fin_err;

  always_comb begin
    we    = 1'b0;
    waddr = AW'(depth);
    wdata = top;
    // spill the old top below the new pushed digit
    if (state == ST_EXEC && !err_seen && cur.cmd == CMD_PUSH && depth != '0 &&
        depth < DW'(STACK_DEPTH)) begin
      we    = 1'b1;
      waddr = AW'(depth - DW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
    if (rst) begin
      state    <= ST_IDLE;
      depth    <= '0;
      err_seen <= 1'b0;
      last_op  <= 1'b0;
      dcnt     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_EXEC: begin
          if (cur.cmd != CMD_NONE) last_op <= op_cmd;
          if (cur.cmd == CMD_BAD) begin
            err_seen <= 1'b1;
          end else if (!err_seen && cur.cmd == CMD_PUSH) begin
            if (depth >= DW'(STACK_DEPTH)) err_seen <= 1'b1;
            else begin
              top   <= {28'd0, cur.digit};
              if (depth == '0) bot0 <= {28'd0, cur.digit};
              depth <= depth + DW'(1);
            end
          end else if (!err_seen && op_cmd) begin
            if (depth < DW'(2)) err_seen <= 1'b1;
            else begin
              case (cur.cmd)
                CMD_ADD: top <= rdata + top;
                CMD_SUB: top <= rdata - top;
                CMD_MUL: top <= rdata * top;
                default: ;
              endcase
              if (cur.cmd == CMD_DIV && top == 32'd0) err_seen <= 1'b1;
              else if (cur.cmd == CMD_DIV) begin
                dq   <= rdata[31] ? -rdata : rdata;
                dd   <= top[31] ? -top : top;
                dr   <= '0;
                dneg <= rdata[31] ^ top[31];
                dcnt <= 6'd32;
              end else begin
                depth <= depth - DW'(1);
                if (depth == DW'(2)) begin
                  case (cur.cmd)
                    CMD_ADD: bot0 <= rdata + top;
                    CMD_SUB: bot0 <= rdata - top;
                    default: bot0 <= rdata * top;
                  endcase
                end
              end
            end
          end
        end
        ST_DIV: begin
          if (dcnt != 6'd0) begin
            // one restoring step per cycle
            if (!dtrial[32]) begin
              dr <= dtrial[31:0];
              dq <= {dq[30:0], 1'b1};
            end else begin
              dr <= {dr[30:0], dq[31]};
              dq <= {dq[30:0], 1'b0};
            end
            dcnt <= dcnt - 6'd1;
          end else begin
            top   <= dneg ? -dq : dq;
            if (depth == DW'(2)) bot0 <= dneg ? -dq : dq;
            depth <= depth - DW'(1);
          end
        end
        ST_OUT: if (!out_stall) begin
          depth    <= '0;
          err_seen <= 1'b0;
          last_op  <= 1'b0;
        end
        default: ;
      endcase
    end
  end
endmodule

@@ hw/rtl/rpn_stack_evaluator.sv @@
// ----------------------------------------------------------------------------
// rpn_stack_evaluator: reverse Polish integer expression evaluator
// Top level joining the classifier front end and the stack back end.
// ----------------------------------------------------------------------------
// Feed one ASCII character per item on in_valid/in_stall with symbol and
// end_of_expr; mark the last character with end_of_expr. Spaces are skipped,
// digits push, + - * / operate on 32-bit wrapping values.
// One result item (value, error) leaves on out_valid/out_stall per
// expression, after its last character has been executed.
// A four-entry command queue decouples input from execution, so characters
// are taken while the back end works or while a result waits.
// Each character passes the IDLE, RD and EXEC states of the back end; a
// division adds the DIV state of the one-bit-per-cycle divider.
// A result adds the OUT state and holds while out_stall is high; the back end
// waits there, the queue keeps filling until full and then stalls input.
// Reset empties the queue and clears stack depth and error state.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         symbol,
  input  logic               end_of_expr,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic               error
);
  import rpn_pkg::*;

  logic  q_valid;
  logic  q_pop;
  qent_t q_data;

  rpn_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .symbol(symbol), .end_of_expr(end_of_expr),
    .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
  );

  rpn_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data),
    .out_valid(out_valid), .out_stall(out_stall), .value(value), .error(error)
  );
endmodule
